[rtl/spfa_pkg.sv]
package spfa_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_PI_GAINS        = 3'd0;
  localparam logic [2:0] REG_INTEGRAL_LIMITS = 3'd1;
  localparam logic [2:0] REG_MODE_THRESHOLDS = 3'd2;
  localparam logic [2:0] REG_ACCEL_Q_LINE    = 3'd3;
  localparam logic [2:0] REG_ACCEL_D_LINE    = 3'd4;
  localparam logic [2:0] REG_DECEL_Q_LINE    = 3'd5;
  localparam logic [2:0] REG_DECEL_D_LINE    = 3'd6;
  localparam logic [2:0] REG_CRUISE_D_LINE   = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int TICK_W     = 11;

  // mode codes
  localparam logic [1:0] MODE_CRUISE = 2'd0;
  localparam logic [1:0] MODE_ACCEL  = 2'd1;
  localparam logic [1:0] MODE_DECEL  = 2'd2;

  localparam logic [TICK_W-1:0] TICK_CEILING = 11'd1000;
  localparam int                PI_SHIFT     = 15;

  typedef struct packed {
    logic signed [15:0] slope;
    logic signed [15:0] offset;
  } line_t;

  typedef struct packed {
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [31:0] ui_min;
    logic signed [31:0] ui_max;
    logic signed [15:0] th_add;
    logic signed [15:0] th_sub;
    logic        [15:0] tick_lim;
    line_t              accel_q;
    line_t              accel_d;
    line_t              decel_q;
    line_t              decel_d;
    line_t              cruise_d;
  } cfg_t;

  typedef struct packed {
    logic [TICK_W-1:0]  ticks;
    logic signed [31:0] integral;
    logic signed [31:0] base;
  } state_t;

  typedef struct packed {
    logic signed [31:0] q_drive;
    logic signed [31:0] d_drive;
    logic [1:0]         mode;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    logic signed [31:0] r;
    if (x > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -36'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/spfa_core.sv]
module spfa_core (
  input  logic signed [15:0] ref_spd,
  input  logic signed [15:0] fdb_spd,
  input  spfa_pkg::cfg_t     cfg,
  input  spfa_pkg::state_t   st,
  output spfa_pkg::state_t   st_nxt,
  output spfa_pkg::result_t  res
);

  logic signed [16:0] err;
  logic signed [16:0] neg_th_sub;
  logic [spfa_pkg::TICK_W-1:0] ticks_clr;
  logic               accel_go;
  logic               decel_go;

  logic signed [32:0] kp_err;
  logic signed [32:0] ki_err;
  logic signed [31:0] up;
  logic signed [31:0] ki_sat;
  logic signed [31:0] ui;
  logic signed [31:0] pi_sum;
  logic signed [16:0] pre;
  logic signed [31:0] base_c;
  logic signed [16:0] floor_v;
  logic signed [31:0] q_c;
  logic signed [16:0] guard_k;
  logic signed [17:0] guard_off;
  logic signed [32:0] guard_prod;
  logic signed [31:0] guard;
  logic signed [16:0] spd;
  logic signed [32:0] cd_prod;
  logic signed [31:0] d_c;
  logic signed [31:0] aq;
  logic signed [31:0] ad;
  logic signed [31:0] dq;
  logic signed [31:0] dd;

  assign err        = 17'(ref_spd) - 17'(fdb_spd);
  assign neg_th_sub = -17'(cfg.th_sub);

  always_comb begin
    if (err < -17'sd5 || ref_spd <= 16'sd0 || st.ticks > spfa_pkg::TICK_CEILING) begin
      ticks_clr = '0;
    end else begin
      ticks_clr = st.ticks;
    end
  end

  assign accel_go = (err > 17'(cfg.th_add)) && ({5'd0, ticks_clr} < cfg.tick_lim);
  assign decel_go = err < neg_th_sub;

  // forced-mode lines
  assign aq = spfa_pkg::sat32(36'(fdb_spd * cfg.accel_q.slope) + 36'(cfg.accel_q.offset));
  assign ad = spfa_pkg::sat32(36'(fdb_spd * cfg.accel_d.slope) + 36'(cfg.accel_d.offset));
  assign dq = spfa_pkg::sat32(36'(fdb_spd * cfg.decel_q.slope) - 36'(cfg.decel_q.offset));
  assign dd = spfa_pkg::sat32(36'(fdb_spd * cfg.decel_d.slope) + 36'(cfg.decel_d.offset));

  // cruise PI path
  assign kp_err = 33'(cfg.kp) * 33'(err);
  assign ki_err = 33'(cfg.ki) * 33'(err);
  assign up     = spfa_pkg::sat32(36'(kp_err));
  assign ki_sat = spfa_pkg::sat32(36'(ki_err));

  assign guard_k    = 17'(cfg.accel_q.slope) - 17'sd40;
  assign guard_off  = 18'(cfg.accel_q.offset) - 18'sd3000;
  assign guard_prod = 33'(fdb_spd) * 33'(guard_k);
  assign guard      = spfa_pkg::sat32(36'(guard_prod) + 36'(guard_off));
  assign floor_v    = 17'(cfg.accel_q.offset) - 17'sd1500;

  always_comb begin
    ui = spfa_pkg::sat32(36'(st.integral) + 36'(ki_sat));
    if (ui < cfg.ui_min) begin
      ui = cfg.ui_min;
    end
    // maximum wins when the limits cross
    if (ui > cfg.ui_max) begin
      ui = cfg.ui_max;
    end
    pi_sum = spfa_pkg::sat32(36'(up) + 36'(ui));
    pre    = 17'(pi_sum >>> spfa_pkg::PI_SHIFT);
    base_c = st.base;
    if (ui < 32'sd0) begin
      base_c = spfa_pkg::sat32(36'(st.base) - 36'sd25);
    end
    if (base_c < 32'(floor_v)) begin
      base_c = 32'(floor_v);
    end
    q_c = spfa_pkg::sat32(36'(base_c) + 36'(pre));
    spd = 17'(fdb_spd) + 17'sd60;
    if (spd > 17'(ref_spd)) begin
      spd = 17'(ref_spd);
    end
  end

  assign cd_prod = 33'(spd) * 33'(cfg.cruise_d.slope);
  assign d_c     = spfa_pkg::sat32(36'(cd_prod) + 36'(cfg.cruise_d.offset));

  always_comb begin
    priority if (accel_go) begin
      st_nxt.ticks    = ticks_clr + 11'd1;
      st_nxt.integral = '0;
      st_nxt.base     = aq;
      res.q_drive     = aq;
      res.d_drive     = ad;
      res.mode        = spfa_pkg::MODE_ACCEL;
    end else if (decel_go) begin
      st_nxt.ticks    = ticks_clr;
      st_nxt.integral = '0;
      st_nxt.base     = dq;
      res.q_drive     = dq;
      res.d_drive     = dd;
      res.mode        = spfa_pkg::MODE_DECEL;
    end else begin
      st_nxt.ticks    = ticks_clr;
      // anti-windup: drop a negative integral when q sits under the guard line
      st_nxt.integral = (q_c < guard && ui < 32'sd0) ? 32'sd0 : ui;
      st_nxt.base     = base_c;
      res.q_drive     = q_c;
      res.d_drive     = d_c;
      res.mode        = spfa_pkg::MODE_CRUISE;
    end
  end

endmodule

[rtl/speed_pi_with_forced_accel.sv]
// Speed controller with forced-acceleration, forced-deceleration and cruise PI
// modes. One transaction on the in_ channel (reference and measured speed)
// gives one transaction on the out_ channel (q drive, d drive, mode). The
// input is captured in a register, the whole mode decision, PI update and
// line evaluation run combinationally behind it into the result register,
// and the controller state is updated on the same edge. One transaction can
// be accepted every cycle while out_ready does not stall the result side.
// The clock period is set by that single combinational pass (eight 16x16 or
// 16x17 multipliers in parallel plus the saturating add chain of the cruise
// path). Configuration is written through cfg_we/cfg_index/cfg_wdata; the
// user must write it only while idle, the block itself does not enforce this.
module speed_pi_with_forced_accel (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [15:0]                  in_target_speed,
  input  logic signed [15:0]                  in_measured_speed,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  out_q_drive,
  output logic signed [31:0]                  out_d_drive,
  output logic [1:0]                          out_mode,
  input  logic                                cfg_we,
  input  logic [spfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spfa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  spfa_pkg::cfg_t    cfg_r;
  spfa_pkg::state_t  st_r;
  spfa_pkg::state_t  st_nxt;
  spfa_pkg::result_t res;
  spfa_pkg::result_t res_r;

  logic               s1_valid_r;
  logic signed [15:0] s1_ref_r;
  logic signed [15:0] s1_fdb_r;
  logic               s1_fire;
  logic               out_valid_r;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spfa_pkg::REG_PI_GAINS: begin
          cfg_r.kp <= cfg_wdata[15:0];
          cfg_r.ki <= cfg_wdata[31:16];
        end
        spfa_pkg::REG_INTEGRAL_LIMITS: begin
          cfg_r.ui_min <= cfg_wdata[31:0];
          cfg_r.ui_max <= cfg_wdata[63:32];
        end
        spfa_pkg::REG_MODE_THRESHOLDS: begin
          cfg_r.th_add   <= cfg_wdata[15:0];
          cfg_r.th_sub   <= cfg_wdata[31:16];
          cfg_r.tick_lim <= cfg_wdata[47:32];
        end
        spfa_pkg::REG_ACCEL_Q_LINE:  cfg_r.accel_q  <= {cfg_wdata[15:0], cfg_wdata[31:16]};
        spfa_pkg::REG_ACCEL_D_LINE:  cfg_r.accel_d  <= {cfg_wdata[15:0], cfg_wdata[31:16]};
        spfa_pkg::REG_DECEL_Q_LINE:  cfg_r.decel_q  <= {cfg_wdata[15:0], cfg_wdata[31:16]};
        spfa_pkg::REG_DECEL_D_LINE:  cfg_r.decel_d  <= {cfg_wdata[15:0], cfg_wdata[31:16]};
        spfa_pkg::REG_CRUISE_D_LINE: cfg_r.cruise_d <= {cfg_wdata[15:0], cfg_wdata[31:16]};
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ref_r <= in_target_speed;
      s1_fdb_r <= in_measured_speed;
    end
  end

  spfa_core u_core (
    .ref_spd (s1_ref_r),
    .fdb_spd (s1_fdb_r),
    .cfg     (cfg_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  // state and result advance together per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        st_r <= st_nxt;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_q_drive = res_r.q_drive;
  assign out_d_drive = res_r.d_drive;
  assign out_mode    = res_r.mode;

endmodule

[verif/tb_speed_pi_with_forced_accel.sv]
module tb_speed_pi_with_forced_accel;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASE_ITEMS    = 100;

  typedef enum int {CFG_MODERATE, CFG_WILD, CFG_TOP, CFG_BOTTOM, CFG_ZERO} cfg_style_t;

  class drive_scoreboard;
    localparam longint BLEED_STEP       = 25;
    localparam longint FLOOR_MARGIN     = 1500;
    localparam longint GUARD_MARGIN     = 3000;
    localparam longint GUARD_SLOPE_DROP = 40;
    localparam longint D_SPEED_LEAD     = 60;
    localparam longint TICK_CLEAR_ERR   = -5;

    longint kp, ki, ui_min, ui_max, th_add, th_sub, tick_lim;
    longint aq_k, aq_t, ad_k, ad_t, dq_k, dq_t, dd_k, dd_t, cd_k, cd_t;
    int unsigned ticks;
    longint integral, base;
    spfa_pkg::result_t due_drives[$];
    int mismatches;

    static function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    static function longint field16(logic [63:0] v, int pos);
      logic [15:0] f;
      f = v[pos +: 16];
      return longint'($signed(f));
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        spfa_pkg::REG_PI_GAINS: begin
          kp = field16(data, 0);
          ki = field16(data, 16);
        end
        spfa_pkg::REG_INTEGRAL_LIMITS: begin
          ui_min = longint'($signed(data[31:0]));
          ui_max = longint'($signed(data[63:32]));
        end
        spfa_pkg::REG_MODE_THRESHOLDS: begin
          th_add   = field16(data, 0);
          th_sub   = field16(data, 16);
          tick_lim = longint'(data[47:32]);
        end
        spfa_pkg::REG_ACCEL_Q_LINE: begin
          aq_k = field16(data, 0); aq_t = field16(data, 16);
        end
        spfa_pkg::REG_ACCEL_D_LINE: begin
          ad_k = field16(data, 0); ad_t = field16(data, 16);
        end
        spfa_pkg::REG_DECEL_Q_LINE: begin
          dq_k = field16(data, 0); dq_t = field16(data, 16);
        end
        spfa_pkg::REG_DECEL_D_LINE: begin
          dd_k = field16(data, 0); dd_t = field16(data, 16);
        end
        spfa_pkg::REG_CRUISE_D_LINE: begin
          cd_k = field16(data, 0); cd_t = field16(data, 16);
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return due_drives.size();
    endfunction

    // one control period: mode decision, state update, expected drives
    function void note_speeds(logic signed [15:0] tgt, logic signed [15:0] meas);
      longint r, f, err, up, ui, pre, guard, spd, q, d;
      spfa_pkg::result_t res;
      r   = longint'(tgt);
      f   = longint'(meas);
      err = r - f;
      if (err < TICK_CLEAR_ERR || r <= 0 || ticks > spfa_pkg::TICK_CEILING) ticks = 0;
      up = clamp32(kp * err);
      if (err > th_add && longint'(ticks) < tick_lim) begin
        ticks    = (ticks + 1) & 32'h7FF;
        base     = clamp32(f * aq_k + aq_t);
        integral = 0;
        q        = base;
        d        = clamp32(f * ad_k + ad_t);
        res.mode = spfa_pkg::MODE_ACCEL;
      end else if (err < -th_sub) begin
        base     = clamp32(f * dq_k - dq_t);
        integral = 0;
        q        = base;
        d        = clamp32(f * dd_k + dd_t);
        res.mode = spfa_pkg::MODE_DECEL;
      end else begin
        ui = clamp32(integral + clamp32(ki * err));
        // min first, max second: max wins when the limits cross
        if (ui < ui_min) ui = ui_min;
        if (ui > ui_max) ui = ui_max;
        integral = ui;
        pre = clamp32(up + ui) >>> spfa_pkg::PI_SHIFT;
        if (integral < 0) base = clamp32(base - BLEED_STEP);
        if (base < aq_t - FLOOR_MARGIN) base = aq_t - FLOOR_MARGIN;
        q = clamp32(base + pre);
        guard = clamp32(f * (aq_k - GUARD_SLOPE_DROP) + (aq_t - GUARD_MARGIN));
        if (q < guard && integral < 0) integral = 0;
        spd = f + D_SPEED_LEAD;
        if (spd > r) spd = r;
        d = clamp32(spd * cd_k + cd_t);
        res.mode = spfa_pkg::MODE_CRUISE;
      end
      res.q_drive = 32'(q);
      res.d_drive = 32'(d);
      due_drives.push_back(res);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 50) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_drive(logic signed [31:0] q, logic signed [31:0] d, logic [1:0] m);
      spfa_pkg::result_t want;
      if (due_drives.size() == 0) begin
        report("drive transaction with nothing pending");
        return;
      end
      want = due_drives.pop_front();
      if (q !== want.q_drive)
        report($sformatf("q_drive got %0d want %0d", q, want.q_drive));
      if (d !== want.d_drive)
        report($sformatf("d_drive got %0d want %0d", d, want.d_drive));
      if (m !== want.mode)
        report($sformatf("mode got %0d want %0d", m, want.mode));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_target_speed;
  logic signed [15:0] in_measured_speed;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_q_drive;
  logic signed [31:0] out_d_drive;
  logic [1:0]         out_mode;
  logic               cfg_we;
  logic [spfa_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [spfa_pkg::CFG_DATA_W-1:0] cfg_wdata;

  drive_scoreboard sb;
  logic [63:0] regs [8];
  bit src_idle_en;
  bit stall_en;
  bit hold_off_req;
  int quiet;

  speed_pi_with_forced_accel u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_target_speed   (in_target_speed),
    .in_measured_speed (in_measured_speed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_q_drive       (out_q_drive),
    .out_d_drive       (out_d_drive),
    .out_mode          (out_mode),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int rand_int(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic [31:0] pair16(int hi, int lo);
    return {hi[15:0], lo[15:0]};
  endfunction

  function automatic logic [63:0] pair32(int hi, int lo);
    return {hi[31:0], lo[31:0]};
  endfunction

  function automatic logic [63:0] thresholds(int tick_lim, int th_sub, int th_add);
    return {16'd0, tick_lim[15:0], th_sub[15:0], th_add[15:0]};
  endfunction

  // handshakes are sampled mid-cycle; inputs only move on the rising edge
  always @(negedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && in_ready) sb.note_speeds(in_target_speed, in_measured_speed);
      if (out_valid && out_ready) sb.check_drive(out_q_drive, out_d_drive, out_mode);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (stall_en && $urandom_range(5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(14, 1)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task program_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= regs[i];
      sb.set_reg(3'(i), regs[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task build_cfg(cfg_style_t style);
    int lo, hi, t;
    case (style)
      CFG_MODERATE: begin
        regs[spfa_pkg::REG_PI_GAINS] =
          {32'd0, pair16(rand_int(-1500, 1500), rand_int(-3000, 3000))};
        lo = rand_int(-2000000, 0);
        hi = rand_int(0, 2000000);
        if ($urandom_range(5) == 0) begin
          t = lo; lo = hi; hi = t;
        end
        regs[spfa_pkg::REG_INTEGRAL_LIMITS] = pair32(hi, lo);
        regs[spfa_pkg::REG_MODE_THRESHOLDS] =
          thresholds(rand_int(0, 40), rand_int(0, 300), rand_int(0, 300));
        for (int i = spfa_pkg::REG_ACCEL_Q_LINE; i <= spfa_pkg::REG_CRUISE_D_LINE; i++)
          regs[i] = {32'd0, pair16(rand_int(-5000, 5000), rand_int(-64, 64))};
      end
      CFG_WILD: begin
        for (int i = 0; i < 8; i++) regs[i] = {$urandom, $urandom};
      end
      CFG_TOP: begin
        regs[spfa_pkg::REG_PI_GAINS]        = {32'd0, 32'h7FFF_7FFF};
        regs[spfa_pkg::REG_INTEGRAL_LIMITS] = 64'h7FFF_FFFF_8000_0000;
        regs[spfa_pkg::REG_MODE_THRESHOLDS] = 64'h0000_FFFF_7FFF_7FFF;
        for (int i = spfa_pkg::REG_ACCEL_Q_LINE; i <= spfa_pkg::REG_CRUISE_D_LINE; i++)
          regs[i] = {32'd0, 32'h7FFF_7FFF};
      end
      CFG_BOTTOM: begin
        regs[spfa_pkg::REG_PI_GAINS]        = {32'd0, 32'h8000_8000};
        regs[spfa_pkg::REG_INTEGRAL_LIMITS] = 64'h8000_0000_7FFF_FFFF;
        regs[spfa_pkg::REG_MODE_THRESHOLDS] = 64'h0000_0000_8000_8000;
        for (int i = spfa_pkg::REG_ACCEL_Q_LINE; i <= spfa_pkg::REG_CRUISE_D_LINE; i++)
          regs[i] = {32'd0, 32'h8000_8000};
      end
      default: begin
        for (int i = 0; i < 8; i++) regs[i] = 64'd0;
      end
    endcase
  endtask

  task send_item(int tgt, int meas);
    bit took;
    if (src_idle_en && $urandom_range(5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_target_speed   <= tgt[15:0];
    in_measured_speed <= meas[15:0];
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  // drop valid, wait for every drive to come back, let the pipe empty
  task settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task send_noise();
    int t, m;
    case ($urandom_range(3))
      0: begin
        t = int'($urandom);
        m = int'($urandom);
      end
      1: begin
        t = $urandom_range(1) ? 32767 : -32768;
        m = $urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? 32767 : -32768);
      end
      2: begin
        t = rand_int(-3000, 3000);
        m = t - rand_int(-400, 400);
      end
      default: begin
        t = rand_int(1, 20000);
        m = t - rand_int(-20, 500);
      end
    endcase
    send_item(t, m);
  endtask

  // motor spin-up towards a set speed, with a reversal now and then
  task send_spinup(int len);
    int t, m;
    t = rand_int(100, 12000);
    m = rand_int(-200, 100);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(11) == 0) t = rand_int(-2000, 12000);
      if (m < t) m += rand_int(0, 400);
      else m -= rand_int(0, 60);
      m += rand_int(-30, 30);
      if (m > 32767) m = 32767;
      if (m < -32768) m = -32768;
      send_item(t, m);
    end
  endtask

  task run_phase(int n);
    int sent, len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) < 7) begin
        len = rand_int(5, 20);
        send_spinup(len);
        sent += len;
      end else begin
        send_noise();
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_target_speed   <= '0;
    in_measured_speed <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    src_idle_en  = 1'b1;
    stall_en     = 1'b1;
    hold_off_req = 1'b0;
    quiet        = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick limit of three, thresholds at 100
    regs[spfa_pkg::REG_PI_GAINS]        = {32'd0, pair16(800, 1000)};
    regs[spfa_pkg::REG_INTEGRAL_LIMITS] = pair32(200000, -100000);
    regs[spfa_pkg::REG_MODE_THRESHOLDS] = thresholds(3, 100, 100);
    regs[spfa_pkg::REG_ACCEL_Q_LINE]    = {32'd0, pair16(2000, 3)};
    regs[spfa_pkg::REG_ACCEL_D_LINE]    = {32'd0, pair16(500, -2)};
    regs[spfa_pkg::REG_DECEL_Q_LINE]    = {32'd0, pair16(1000, 2)};
    regs[spfa_pkg::REG_DECEL_D_LINE]    = {32'd0, pair16(300, -1)};
    regs[spfa_pkg::REG_CRUISE_D_LINE]   = {32'd0, pair16(-700, 4)};
    program_regs();
    send_item(32767, -32768);
    send_item(-32768, 32767);
    send_item(1000, 800);
    send_item(1000, 850);
    send_item(1000, 880);
    send_item(1000, 800);   // tick limit reached: cruise
    send_item(1000, 1003);  // small negative error keeps the ticks
    send_item(1000, 1006);  // clears the ticks
    send_item(0, -200);     // non-positive reference clears, then accel
    send_item(500, 600);    // integral goes negative, base bleeds
    send_item(500, 599);
    send_item(500, 601);
    send_item(500, 400);
    send_item(500, 460);    // d speed capped at the reference
    send_item(32767, 32767);
    send_item(-32768, -32768);
    send_item(0, 0);
    send_item(1000, 1000);
    settle();

    // crossed integral limits, extreme gains and lines
    regs[spfa_pkg::REG_PI_GAINS]        = {32'd0, 32'h7FFF_8000};
    regs[spfa_pkg::REG_INTEGRAL_LIMITS] = pair32(-1000, 1000);
    regs[spfa_pkg::REG_MODE_THRESHOLDS] = 64'h0000_FFFF_7FFF_7FFF;
    for (int i = spfa_pkg::REG_ACCEL_Q_LINE; i <= spfa_pkg::REG_CRUISE_D_LINE; i++)
      regs[i] = {32'd0, 32'h7FFF_8000};
    program_regs();
    send_item(32767, -32768);
    send_item(-32768, 32767);
    send_item(32767, 0);
    send_item(-32768, -1);
    settle();

    // integral runs into 32-bit saturation
    build_cfg(CFG_TOP);
    regs[spfa_pkg::REG_MODE_THRESHOLDS] = 64'h0000_0000_7FFF_7FFF;
    program_regs();
    repeat (3) send_item(32767, 0);
    send_item(-32767, 0);
    settle();

    for (int k = 0; k < 8; k++) begin
      case (k)
        3:       build_cfg(CFG_WILD);
        4:       build_cfg(CFG_TOP);
        6:       build_cfg(CFG_BOTTOM);
        7:       build_cfg(CFG_ZERO);
        default: build_cfg(CFG_MODERATE);
      endcase
      program_regs();
      if (k == 2) begin
        src_idle_en  = 1'b0;
        hold_off_req = 1'b1;
      end
      run_phase(PHASE_ITEMS);
      src_idle_en = 1'b1;
      settle();
    end

    src_idle_en = 1'b0;
    stall_en    = 1'b0;
    build_cfg(CFG_MODERATE);
    program_regs();
    run_phase(60);
    settle();
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/spfa_pkg.sv
rtl/spfa_core.sv
rtl/speed_pi_with_forced_accel.sv
verif/tb_speed_pi_with_forced_accel.sv
